// ===== design/assert_macros.svh =====
// Assertion macros shared by the ellipse generator RTL.
// No dependencies; simulation builds see real checks, synthesis sees nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define MPE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that an expression never holds outside reset.
`define MPE_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MPE_ASSERT(label, clk, rst_n, prop, msg)
`define MPE_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== design/mpe_pkg.sv =====
// Shared types and constants of the midpoint ellipse generator.
// No dependencies; used by mpe_ctrl, mpe_dp and the top level.
package mpe_pkg;

	localparam int unsigned COORD_BITS_DEF = 11;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;

	typedef enum logic [3:0] {
		ST_READY,
		ST_STEP,
		ST_SQA,
		ST_SQB,
		ST_AB,
		ST_INIT,
		ST_E1,
		ST_E2,
		ST_E3,
		ST_E4,
		ST_E5,
		ST_E6
	} state_t;

	typedef enum logic [1:0] {
		REG_IDLE = 2'd0,
		REG_ONE  = 2'd1,
		REG_TWO  = 2'd2
	} region_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_AA,
		MUL_BB,
		MUL_A2B,
		MUL_XX,
		MUL_B2P,
		MUL_YY,
		MUL_A2P,
		MUL_A2B2
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_A2,
		ACC_B2,
		ACC_INIT,
		ACC_SET,
		ACC_ADD4,
		ACC_R2DEC,
		ACC_STEP
	} acc_op_t;

	typedef struct packed {
		logic     ld_start;
		logic     step_move;
		logic     out_load;
		logic     out_done;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		region_t  region;
	} dp_cmd_t;

	typedef struct packed {
		logic tx_lt_ty;
		logic prod_zero;
		logic y_le0;
	} dp_stat_t;

endpackage

// ===== design/mpe_dp.sv =====
// Datapath of the ellipse generator: position, incremental terms, decision value,
// one shared multiplier and the result register. Depends on mpe_pkg, assert_macros.svh.
`include "assert_macros.svh"

module mpe_dp #(
	parameter int unsigned COORD_BITS = mpe_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mpe_pkg::dp_cmd_t              cmd,
	output mpe_pkg::dp_stat_t             stat,
	input  logic signed [COORD_BITS-1:0]  center_x,
	input  logic signed [COORD_BITS-1:0]  center_y,
	input  logic signed [COORD_BITS-1:0]  corner_x,
	input  logic signed [COORD_BITS-1:0]  corner_y,
	output logic signed [COORD_BITS+1:0]  px_right,
	output logic signed [COORD_BITS+1:0]  px_left,
	output logic signed [COORD_BITS+1:0]  py_top,
	output logic signed [COORD_BITS+1:0]  py_bottom,
	output logic                          last_point,
	output logic                          done_res
);

	localparam int unsigned C      = COORD_BITS;
	localparam int unsigned SQ_W   = 2 * C;
	localparam int unsigned X_W    = C + 1;
	localparam int unsigned Y_W    = C + 2;
	localparam int unsigned OUT_W  = C + 2;
	localparam int unsigned MUL_W  = 2 * C + 4;
	localparam int unsigned PROD_W = 2 * MUL_W;
	localparam int unsigned T_W    = 3 * C + 6;
	localparam int unsigned DEC_W  = 4 * C + 6;

	localparam logic signed [Y_W:0]       ONE_Y  = (Y_W + 1)'(1);
	localparam logic signed [DEC_W-1:0]   ZERO_D = '0;
	localparam logic signed [OUT_W-1:0]   ZERO_O = '0;

	logic signed [C-1:0]     org_x_q, org_y_q;
	logic        [C-1:0]     a_q, b_q;
	logic        [SQ_W-1:0]  a2_q, b2_q;
	logic        [X_W-1:0]   x_q;
	logic signed [Y_W-1:0]   y_q;
	logic signed [T_W-1:0]   tx_q, ty_q;
	logic signed [DEC_W-1:0] dec_q, acc_q;
	logic        [PROD_W-1:0] prod_q;
	logic                    xmv_q, ymv_q;

	logic signed [OUT_W-1:0] px_right_q, px_left_q, py_top_q, py_bottom_q;
	logic                    last_q, done_q;

	logic signed [C:0]       dx, dy, dx_abs, dy_abs;
	logic signed [Y_W:0]     ym1, ym1_abs;
	logic        [X_W:0]     ox;
	logic        [MUL_W-1:0] op_a, op_b, prod_lo;
	logic        [PROD_W-1:0] prod_d;
	logic                    dec_neg, dec_zero, mv_x, mv_y;
	logic signed [T_W-1:0]   a2x8, b2x8;
	logic signed [DEC_W-1:0] a2_d, b2_d, pr_d, tx_d, ty_d, stp_x, stp_y, stp_c;
	logic signed [OUT_W-1:0] ox_e, x_e, oy_e;

	// semi-axes from the start beat
	always_comb begin
		dx     = $signed({corner_x[C-1], corner_x}) - $signed({center_x[C-1], center_x});
		dy     = $signed({corner_y[C-1], corner_y}) - $signed({center_y[C-1], center_y});
		dx_abs = dx[C] ? -dx : dx;
		dy_abs = dy[C] ? -dy : dy;
	end

	// shared multiplier operands
	always_comb begin
		ox      = {x_q, 1'b1};
		ym1     = $signed({y_q[Y_W-1], y_q}) - ONE_Y;
		ym1_abs = ym1[Y_W] ? -ym1 : ym1;
		prod_lo = prod_q[MUL_W-1:0];
		unique case (cmd.mul_sel)
			mpe_pkg::MUL_AA: begin
				op_a = MUL_W'(a_q);
				op_b = MUL_W'(a_q);
			end
			mpe_pkg::MUL_BB: begin
				op_a = MUL_W'(b_q);
				op_b = MUL_W'(b_q);
			end
			mpe_pkg::MUL_A2B: begin
				op_a = MUL_W'(a2_q);
				op_b = MUL_W'(b_q);
			end
			mpe_pkg::MUL_XX: begin
				op_a = MUL_W'(ox);
				op_b = MUL_W'(ox);
			end
			mpe_pkg::MUL_B2P: begin
				op_a = MUL_W'(b2_q);
				op_b = prod_lo;
			end
			mpe_pkg::MUL_YY: begin
				op_a = MUL_W'($unsigned(ym1_abs));
				op_b = MUL_W'($unsigned(ym1_abs));
			end
			mpe_pkg::MUL_A2P: begin
				op_a = MUL_W'(a2_q);
				op_b = prod_lo;
			end
			mpe_pkg::MUL_A2B2: begin
				op_a = MUL_W'(a2_q);
				op_b = MUL_W'(b2_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
		prod_d = PROD_W'(op_a) * PROD_W'(op_b);
	end

	// step direction from the decision sign
	always_comb begin
		dec_neg  = dec_q[DEC_W-1];
		dec_zero = (dec_q == ZERO_D);
		unique case (cmd.region)
			mpe_pkg::REG_ONE: begin
				mv_x = 1'b1;
				mv_y = !(dec_neg || dec_zero);
			end
			mpe_pkg::REG_TWO: begin
				mv_x = dec_neg;
				mv_y = 1'b1;
			end
			default: begin
				mv_x = 1'b0;
				mv_y = 1'b0;
			end
		endcase
	end

	always_comb begin
		a2x8  = $signed(T_W'({a2_q, 3'b000}));
		b2x8  = $signed(T_W'({b2_q, 3'b000}));
		a2_d  = $signed(DEC_W'(a2_q));
		b2_d  = $signed(DEC_W'(b2_q));
		pr_d  = $signed(prod_q[DEC_W-1:0]);
		tx_d  = DEC_W'(tx_q);
		ty_d  = DEC_W'(ty_q);
		stp_x = xmv_q ? tx_d : ZERO_D;
		stp_y = ymv_q ? ty_d : ZERO_D;
		stp_c = (cmd.region == mpe_pkg::REG_ONE) ? (b2_d <<< 2) : (a2_d <<< 2);
		ox_e  = OUT_W'(org_x_q);
		oy_e  = OUT_W'(org_y_q);
		x_e   = $signed(OUT_W'(x_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= '0;
		end else if (cmd.mul_sel != mpe_pkg::MUL_NONE) begin
			prod_q <= prod_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q <= '0;
			org_y_q <= '0;
			a_q     <= '0;
			b_q     <= '0;
		end else if (cmd.ld_start) begin
			org_x_q <= center_x;
			org_y_q <= center_y;
			a_q     <= dx_abs[C-1:0];
			b_q     <= dy_abs[C-1:0];
		end
	end

	// position and the running 8*b2*x, 8*a2*y terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			tx_q  <= '0;
			ty_q  <= '0;
			xmv_q <= 1'b0;
			ymv_q <= 1'b0;
		end else if (cmd.ld_start) begin
			x_q  <= '0;
			y_q  <= $signed(Y_W'(dy_abs[C-1:0]));
			tx_q <= '0;
			ty_q <= '0;
		end else if (cmd.step_move) begin
			x_q   <= x_q + X_W'(mv_x);
			y_q   <= y_q - $signed(Y_W'(mv_y));
			tx_q  <= mv_x ? tx_q + b2x8 : tx_q;
			ty_q  <= mv_y ? ty_q - a2x8 : ty_q;
			xmv_q <= mv_x;
			ymv_q <= mv_y;
		end else if (cmd.acc_op == mpe_pkg::ACC_INIT) begin
			ty_q <= $signed({prod_q[T_W-4:0], 3'b000});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a2_q  <= '0;
			b2_q  <= '0;
			dec_q <= '0;
			acc_q <= '0;
		end else begin
			unique case (cmd.acc_op)
				mpe_pkg::ACC_NONE:  ;
				mpe_pkg::ACC_A2:    a2_q  <= prod_q[SQ_W-1:0];
				mpe_pkg::ACC_B2:    b2_q  <= prod_q[SQ_W-1:0];
				mpe_pkg::ACC_INIT:  dec_q <= (b2_d <<< 2) - (pr_d <<< 2) + a2_d;
				mpe_pkg::ACC_SET:   acc_q <= pr_d;
				mpe_pkg::ACC_ADD4:  acc_q <= acc_q + (pr_d <<< 2);
				mpe_pkg::ACC_R2DEC: dec_q <= acc_q - (pr_d <<< 2);
				mpe_pkg::ACC_STEP:  dec_q <= dec_q + stp_x - stp_y + stp_c;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_right_q  <= '0;
			px_left_q   <= '0;
			py_top_q    <= '0;
			py_bottom_q <= '0;
			last_q      <= 1'b0;
			done_q      <= 1'b0;
		end else if (cmd.out_load) begin
			if (cmd.out_done) begin
				px_right_q  <= ZERO_O;
				px_left_q   <= ZERO_O;
				py_top_q    <= ZERO_O;
				py_bottom_q <= ZERO_O;
				last_q      <= 1'b0;
				done_q      <= 1'b1;
			end else begin
				px_right_q  <= ox_e + x_e;
				px_left_q   <= ox_e - x_e;
				py_top_q    <= oy_e + y_q;
				py_bottom_q <= oy_e - y_q;
				last_q      <= (cmd.region == mpe_pkg::REG_TWO) && stat.y_le0;
				done_q      <= 1'b0;
			end
		end
	end

	assign stat.tx_lt_ty  = (tx_q < ty_q);
	assign stat.prod_zero = (prod_q == '0);
	assign stat.y_le0     = y_q[Y_W-1] || (y_q == '0);

	assign px_right   = px_right_q;
	assign px_left    = px_left_q;
	assign py_top     = py_top_q;
	assign py_bottom  = py_bottom_q;
	assign last_point = last_q;
	assign done_res   = done_q;

	`MPE_ASSERT(a_r1_step_moves_x, clk, arst_n, $past(arst_n) && $past(cmd.step_move) && ($past(cmd.region) == mpe_pkg::REG_ONE) |-> (x_q == X_W'($past(x_q) + 1'b1)), "region 1 step did not advance x")

endmodule

// ===== design/mpe_ctrl.sv =====
// Controller of the ellipse generator: sequencer state, region and output handshake.
// Depends on mpe_pkg and assert_macros.svh; drives mpe_dp through dp_cmd_t.
`include "assert_macros.svh"

module mpe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	output logic              out_valid,
	input  logic              out_ready,
	input  mpe_pkg::dp_stat_t stat,
	output mpe_pkg::dp_cmd_t  cmd
);

	mpe_pkg::state_t  state_q, state_d;
	mpe_pkg::region_t region_q, region_d;
	logic             out_valid_q;
	logic             accept, step_acc, start_acc;

	assign in_ready  = (state_q == mpe_pkg::ST_READY) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign step_acc  = accept && (req_type == mpe_pkg::REQ_STEP);
	assign start_acc = accept && (req_type == mpe_pkg::REQ_START);

	always_comb begin
		state_d  = state_q;
		region_d = region_q;
		unique case (state_q)
			mpe_pkg::ST_READY: begin
				if (start_acc) begin
					state_d  = mpe_pkg::ST_SQA;
					region_d = mpe_pkg::REG_ONE;
				end else if (step_acc) begin
					if ((region_q == mpe_pkg::REG_TWO) && stat.y_le0) begin
						region_d = mpe_pkg::REG_IDLE;
					end else if (region_q != mpe_pkg::REG_IDLE) begin
						state_d = mpe_pkg::ST_STEP;
					end
				end
			end
			mpe_pkg::ST_STEP: begin
				if ((region_q == mpe_pkg::REG_ONE) && !stat.tx_lt_ty) begin
					state_d = mpe_pkg::ST_E1;
				end else begin
					state_d = mpe_pkg::ST_READY;
				end
			end
			mpe_pkg::ST_SQA: state_d = mpe_pkg::ST_SQB;
			mpe_pkg::ST_SQB: state_d = mpe_pkg::ST_AB;
			mpe_pkg::ST_AB:  state_d = mpe_pkg::ST_INIT;
			mpe_pkg::ST_INIT: begin
				state_d = stat.prod_zero ? mpe_pkg::ST_E1 : mpe_pkg::ST_READY;
			end
			mpe_pkg::ST_E1: state_d = mpe_pkg::ST_E2;
			mpe_pkg::ST_E2: state_d = mpe_pkg::ST_E3;
			mpe_pkg::ST_E3: state_d = mpe_pkg::ST_E4;
			mpe_pkg::ST_E4: state_d = mpe_pkg::ST_E5;
			mpe_pkg::ST_E5: state_d = mpe_pkg::ST_E6;
			mpe_pkg::ST_E6: begin
				state_d  = mpe_pkg::ST_READY;
				region_d = mpe_pkg::REG_TWO;
			end
			default: state_d = mpe_pkg::ST_READY;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.mul_sel   = mpe_pkg::MUL_NONE;
		cmd.acc_op    = mpe_pkg::ACC_NONE;
		cmd.region    = region_q;
		unique case (state_q)
			mpe_pkg::ST_READY: begin
				cmd.ld_start  = start_acc;
				cmd.step_move = step_acc && (region_q != mpe_pkg::REG_IDLE);
				cmd.out_load  = step_acc;
				cmd.out_done  = (region_q == mpe_pkg::REG_IDLE);
			end
			mpe_pkg::ST_STEP: cmd.acc_op = mpe_pkg::ACC_STEP;
			mpe_pkg::ST_SQA:  cmd.mul_sel = mpe_pkg::MUL_AA;
			mpe_pkg::ST_SQB: begin
				cmd.mul_sel = mpe_pkg::MUL_BB;
				cmd.acc_op  = mpe_pkg::ACC_A2;
			end
			mpe_pkg::ST_AB: begin
				cmd.mul_sel = mpe_pkg::MUL_A2B;
				cmd.acc_op  = mpe_pkg::ACC_B2;
			end
			mpe_pkg::ST_INIT: cmd.acc_op = mpe_pkg::ACC_INIT;
			mpe_pkg::ST_E1:   cmd.mul_sel = mpe_pkg::MUL_XX;
			mpe_pkg::ST_E2:   cmd.mul_sel = mpe_pkg::MUL_B2P;
			mpe_pkg::ST_E3: begin
				cmd.mul_sel = mpe_pkg::MUL_YY;
				cmd.acc_op  = mpe_pkg::ACC_SET;
			end
			mpe_pkg::ST_E4: cmd.mul_sel = mpe_pkg::MUL_A2P;
			mpe_pkg::ST_E5: begin
				cmd.mul_sel = mpe_pkg::MUL_A2B2;
				cmd.acc_op  = mpe_pkg::ACC_ADD4;
			end
			mpe_pkg::ST_E6: cmd.acc_op = mpe_pkg::ACC_R2DEC;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mpe_pkg::ST_READY;
			region_q    <= mpe_pkg::REG_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			region_q <= region_d;
			if (step_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`MPE_ASSERT(a_step_after_accept, clk, arst_n, (state_q == mpe_pkg::ST_STEP) |-> $past(step_acc), "decision update without a step beat")
	`MPE_ASSERT(a_result_after_step, clk, arst_n, $rose(out_valid_q) |-> $past(step_acc), "result raised without a step beat")
	`MPE_ASSERT(a_region2_entry, clk, arst_n, (region_q == mpe_pkg::REG_TWO) && ($past(region_q) != mpe_pkg::REG_TWO) |-> ($past(state_q) == mpe_pkg::ST_E6), "region 2 entered outside the switch sequence")

endmodule

// ===== design/midpoint_ellipse_generator_unit.sv =====
// Top level of the midpoint ellipse generator: stream ports, field packing.
// Depends on mpe_pkg, mpe_ctrl and mpe_dp.
//
//   Channel  Dir  Handshake          Payload
//   s_*      in   s_tvalid/s_tready  tuser: req_type; tdata: center_x, center_y,
//                                    corner_x, corner_y
//   m_*      out  m_tvalid/m_tready  tuser: done_res; tlast: last_point;
//                                    tdata: px_right, px_left, py_top, py_bottom
//
// Step beat on an active ellipse: moves the position, then updates the decision;
// the step that emits the last point skips the update.
// Step beat while idle: answered with done_res set.
// Start beat: squares the semi-axes and sets the decision; the region-2 switch sequence
// follows when the ellipse begins in region 2 (a zero semi-axis), and also when a region-1
// step crosses into region 2. Both use the single shared multiplier, one product per cycle.
// Reset (arst_n low) clears all state; the block comes up idle.
// A result waits in the output register; a new beat is taken once it is drained.
module midpoint_ellipse_generator_unit #(
	parameter int unsigned COORD_BITS = mpe_pkg::COORD_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     s_tvalid,
	output logic                                     s_tready,
	// center_x, center_y, corner_x, corner_y from bit 0 up, zero padded to bytes
	input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// req_type
	input  logic                                     s_tuser,
	output logic                                     m_tvalid,
	input  logic                                     m_tready,
	// px_right, px_left, py_top, py_bottom from bit 0 up, zero padded to bytes
	output logic [((4 * (COORD_BITS + 2) + 7) / 8) * 8 - 1:0] m_tdata,
	// last_point
	output logic                                     m_tlast,
	// done_res
	output logic                                     m_tuser
);

	localparam int unsigned C        = COORD_BITS;
	localparam int unsigned OUT_W    = C + 2;
	localparam int unsigned OUT_TD_W = ((4 * OUT_W + 7) / 8) * 8;

	mpe_pkg::dp_cmd_t  cmd;
	mpe_pkg::dp_stat_t stat;

	logic signed [C-1:0]     center_x, center_y, corner_x, corner_y;
	logic signed [OUT_W-1:0] px_right, px_left, py_top, py_bottom;

	// unpack the input beat, first field in the lowest bits
	assign center_x = $signed(s_tdata[0 * C +: C]);
	assign center_y = $signed(s_tdata[1 * C +: C]);
	assign corner_x = $signed(s_tdata[2 * C +: C]);
	assign corner_y = $signed(s_tdata[3 * C +: C]);

	// sequencer: owns the handshake, the region and the multiplier schedule
	mpe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.req_type  (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: position, decision value, shared multiplier, result register
	mpe_dp #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.center_x   (center_x),
		.center_y   (center_y),
		.corner_x   (corner_x),
		.corner_y   (corner_y),
		.px_right   (px_right),
		.px_left    (px_left),
		.py_top     (py_top),
		.py_bottom  (py_bottom),
		.last_point (m_tlast),
		.done_res   (m_tuser)
	);

	// pack the result beat, zero fill up to whole bytes
	assign m_tdata = OUT_TD_W'({py_bottom, py_top, px_left, px_right});

endmodule

// ===== sim/ellipse_point_checker.sv =====
// Checker for the midpoint ellipse generator: watches both stream channels,
// predicts the point beats and compares them. Depends on mpe_pkg.
module ellipse_point_checker #(
	parameter int CB = mpe_pkg::COORD_BITS_DEF,
	parameter int SW = ((4 * CB + 7) / 8) * 8,
	parameter int MW = ((4 * (CB + 2) + 7) / 8) * 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	input  logic          s_tready,
	input  logic [SW-1:0] s_tdata,
	input  logic          s_tuser,
	input  logic          m_tvalid,
	input  logic          m_tready,
	input  logic [MW-1:0] m_tdata,
	input  logic          m_tlast,
	input  logic          m_tuser,
	output int            mismatches,
	output int            outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int OB = CB + 2;

	typedef struct packed {
		logic [OB-1:0] right;
		logic [OB-1:0] left;
		logic [OB-1:0] top;
		logic [OB-1:0] bottom;
		logic          last;
		logic          done;
	} point_beat_t;

	point_beat_t expected_points[$];

	// tracer state: center, squared semi-axes, offset, 4x decision value
	longint            org_x, org_y, pos_x, pos_y;
	bit [63:0]         a_sq, b_sq, dec;
	mpe_pkg::region_t  rgn;

	initial mismatches = 0;

	function bit in_region1();
		if (pos_y < 0)
			return 1'b0;
		return b_sq * 64'(pos_x) < a_sq * 64'(pos_y);
	endfunction

	function void enter_region2();
		bit [63:0] tx, ty;
		tx = 2 * 64'(pos_x) + 1;
		ty = 64'(pos_y) - 1;
		dec = b_sq * tx * tx + 4 * a_sq * ty * ty - 4 * a_sq * b_sq;
		rgn = mpe_pkg::REG_TWO;
	endfunction

	function void check_field(string name, logic [OB-1:0] want, logic [OB-1:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// append one predicted beat at the tail of the queue
	function void queue_point(point_beat_t pt);
		expected_points.insert(expected_points.size(), pt);
	endfunction

	task predict_beat(input logic req, input logic [SW-1:0] payload);
		longint      cx, cy, da, db;
		point_beat_t pt;
		pt = '0;
		if (req == mpe_pkg::REQ_START) begin
			cx = longint'($signed(payload[0 +: CB]));
			cy = longint'($signed(payload[CB +: CB]));
			da = longint'($signed(payload[2*CB +: CB])) - cx;
			db = longint'($signed(payload[3*CB +: CB])) - cy;
			if (da < 0) da = -da;
			if (db < 0) db = -db;
			org_x = cx;
			org_y = cy;
			a_sq  = 64'(da) * 64'(da);
			b_sq  = 64'(db) * 64'(db);
			pos_x = 0;
			pos_y = db;
			dec   = 4 * b_sq - 4 * a_sq * 64'(db) + a_sq;
			rgn   = mpe_pkg::REG_ONE;
			if (!in_region1())
				enter_region2();
			return;
		end
		if (rgn == mpe_pkg::REG_IDLE) begin
			pt.done = 1'b1;
			queue_point(pt);
			return;
		end
		pt.right  = OB'(org_x + pos_x);
		pt.left   = OB'(org_x - pos_x);
		pt.top    = OB'(org_y + pos_y);
		pt.bottom = OB'(org_y - pos_y);
		if (rgn == mpe_pkg::REG_ONE) begin
			pos_x++;
			if (dec[63] || dec == 0) begin
				dec += 8 * b_sq * 64'(pos_x) + 4 * b_sq;
			end else begin
				pos_y--;
				dec += 8 * b_sq * 64'(pos_x) - 8 * a_sq * 64'(pos_y) + 4 * b_sq;
			end
			if (!in_region1())
				enter_region2();
		end else begin
			pos_y--;
			if (!dec[63]) begin
				dec += 4 * a_sq - 8 * a_sq * 64'(pos_y);
			end else begin
				pos_x++;
				dec += 8 * b_sq * 64'(pos_x) - 8 * a_sq * 64'(pos_y) + 4 * a_sq;
			end
			if (pos_y < 0) begin
				rgn = mpe_pkg::REG_IDLE;
				pt.last = 1'b1;
			end
		end
		queue_point(pt);
	endtask

	always @(posedge clk or negedge arst_n) begin
		point_beat_t want;
		if (!arst_n) begin
			org_x = 0;
			org_y = 0;
			pos_x = 0;
			pos_y = 0;
			a_sq  = '0;
			b_sq  = '0;
			dec   = '0;
			rgn   = mpe_pkg::REG_IDLE;
			expected_points.delete();
			outstanding = 0;
		end else begin
			// a result can never stem from the beat taken at the same edge
			if (m_tvalid && m_tready) begin
				if (expected_points.size() == 0) begin
					mismatches++;
					$display("%0t unexpected result: expected none actual %h last %b done %b",
						$time, m_tdata, m_tlast, m_tuser);
				end else begin
					want = expected_points.pop_front();
					check_field("px_right", want.right, m_tdata[0 +: OB]);
					check_field("px_left", want.left, m_tdata[OB +: OB]);
					check_field("py_top", want.top, m_tdata[2*OB +: OB]);
					check_field("py_bottom", want.bottom, m_tdata[3*OB +: OB]);
					check_field("last_point", OB'(want.last), OB'(m_tlast));
					check_field("done_res", OB'(want.done), OB'(m_tuser));
				end
			end
			if (s_tvalid && s_tready)
				predict_beat(s_tuser, s_tdata);
			outstanding = expected_points.size();
		end
	end

endmodule

// ===== sim/midpoint_ellipse_generator_unit_tb.sv =====
// Testbench top for the midpoint ellipse generator: stimulus, flow control, verdict.
// Depends on mpe_pkg, the generator RTL and ellipse_point_checker.
module midpoint_ellipse_generator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = mpe_pkg::COORD_BITS_DEF;
	localparam int SW = ((4 * CB + 7) / 8) * 8;
	localparam int MW = ((4 * (CB + 2) + 7) / 8) * 8;
	// generous bound: every beat at the slowest block path plus long random stalls
	localparam int CYCLE_LIMIT = 200000;
	// long enough to cover a start that begins in region 2 plus the output register
	localparam int SETTLE_CYCLES = 32;
	localparam int HOLD_CYCLES = 300;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	// center_x, center_y, corner_x, corner_y from bit 0 up, zero padded
	logic [SW-1:0] s_tdata;
	// req_type
	logic          s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	// px_right, px_left, py_top, py_bottom from bit 0 up, zero padded
	logic [MW-1:0] m_tdata;
	// last_point
	logic          m_tlast;
	// done_res
	logic          m_tuser;

	int fail_count;
	int waiting_points;
	int beats_sent = 0;
	int cycle_count = 0;
	int src_idle_pct;
	int sink_idle_pct;
	logic start_hold = 1'b0;
	logic sink_hold;

	midpoint_ellipse_generator_unit #(.COORD_BITS(CB)) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	ellipse_point_checker #(.CB(CB), .SW(SW), .MW(MW)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser),
		.mismatches (fail_count),
		.outstanding(waiting_points)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Hold reset low at the start, then release it for good.
	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: drop tready at random per the current idle rate, and
	// hold it low for the whole pressure window.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			m_tready <= !sink_hold && ($urandom_range(0, 99) >= sink_idle_pct);
		end
	end

	// Pressure window: count it here so the sender keeps offering beats
	// and the block backs up into s_tready.
	initial begin
		sink_hold <= 1'b0;
		wait (start_hold);
		@(posedge clk);
		sink_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		sink_hold <= 1'b0;
	end

	function automatic logic [SW-1:0] pack_coords(int cx, int cy, int ex, int ey);
		logic [SW-1:0] payload;
		payload = '0;
		payload[0 +: CB]    = CB'(cx);
		payload[CB +: CB]   = CB'(cy);
		payload[2*CB +: CB] = CB'(ex);
		payload[3*CB +: CB] = CB'(ey);
		return payload;
	endfunction

	function automatic int rand_coord();
		return int'($urandom_range(0, (1 << CB) - 1)) - (1 << (CB - 1));
	endfunction

	// Offer one beat after a random idle gap; return at the edge that takes it.
	// tvalid stays high into the next beat unless a gap follows.
	task send_beat(input logic req, input logic [SW-1:0] payload);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= payload;
		do @(posedge clk); while (!s_tready);
		beats_sent++;
	endtask

	task send_start(input int cx, input int cy, input int ex, input int ey);
		send_beat(mpe_pkg::REQ_START, pack_coords(cx, cy, ex, ey));
	endtask

	// Step beats carry random coordinates the block must ignore.
	task send_step();
		send_beat(mpe_pkg::REQ_STEP, pack_coords(rand_coord(), rand_coord(), rand_coord(),
			rand_coord()));
	endtask

	task send_random_start();
		send_start(rand_coord(), rand_coord(), rand_coord(), rand_coord());
	endtask

	// Trace one ellipse to its last point: each step moves x, y or both,
	// so a + b + 2 steps always reach the end; a spare step may hit idle.
	task trace_ellipse(input int max_axis);
		int a, b, cx, cy, n;
		a  = $urandom_range(0, max_axis);
		b  = $urandom_range(0, max_axis);
		cx = int'($urandom_range(0, (1 << CB) - 1 - 2 * max_axis))
			- (1 << (CB - 1)) + max_axis;
		cy = int'($urandom_range(0, (1 << CB) - 1 - 2 * max_axis))
			- (1 << (CB - 1)) + max_axis;
		send_start(cx, cy, $urandom_range(0, 1) ? cx + a : cx - a,
			$urandom_range(0, 1) ? cy + b : cy - b);
		n = a + b + 2 + $urandom_range(0, 1);
		repeat (n) send_step();
	endtask

	// Mostly complete small ellipses, some complete larger ones; the rest are
	// cut-off traces of full-range ellipses and lone beats.
	task play_random(input int upto);
		int pick;
		while (beats_sent < upto) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				trace_ellipse(12);
			end else if (pick < 75) begin
				trace_ellipse(40);
			end else if (pick < 88) begin
				send_random_start();
				repeat ($urandom_range(0, 6)) send_step();
			end else if (pick < 94) begin
				send_step();
			end else begin
				send_random_start();
			end
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tuser  <= mpe_pkg::REQ_STEP;
		s_tdata  <= '0;
		src_idle_pct  = 35;
		sink_idle_pct = 60;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// step with nothing active: answered with done
		send_step();
		// widest axes from opposite corners of the coordinate range
		send_start(-1024, -1024, 1023, 1023);
		send_step();
		send_step();
		// restart while active, corner below and left of the center
		send_start(1023, 1023, -1024, -1024);
		send_step();
		send_step();
		// single point, then a step on the idle block
		send_start(0, 0, 0, 0);
		send_step();
		send_step();
		// flat line: zero vertical semi-axis skips region 1
		send_start(-5, 7, -2, 7);
		send_step();
		send_step();
		// upright line: zero horizontal semi-axis
		send_start(100, -200, 100, -197);
		repeat (5) send_step();

		play_random(270);
		src_idle_pct  = 60;
		sink_idle_pct = 35;
		play_random(535);
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		start_hold = 1'b1;
		play_random(800);
		s_tvalid <= 1'b0;

		// drain every expected point, then let any late beat show up
		@(posedge clk);
		while (waiting_points != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
